>>> rtl/tssd_pkg.sv
// Shared types, constants and the digit font for the thermometer display driver.
`timescale 1ns / 1ps

package tssd_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int SEG_W     = 8;
  localparam int SEL_W     = 4;
  localparam int TEMP_W    = 10;
  localparam int REF_W     = 13;
  localparam int THR_W     = 10;
  localparam int DIGITS    = 4;
  localparam int DIG_IDX_W = 2;
  localparam int DIGIT_W   = 4;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic [REF_W-1:0]  REF_RESET  = 13'd5000;
  localparam logic [THR_W-1:0]  THR_RESET  = 10'd350;
  localparam logic [TEMP_W-1:0] TEMP_MAX   = 10'd999;
  localparam logic [SEG_W-1:0]  SEG_BLANK  = 8'h00;
  localparam logic [SEG_W-1:0]  SEG_DP     = 8'h80;
  localparam logic [SEL_W-1:0]  SEL_NONE   = 4'hF;
  localparam logic [DIG_IDX_W-1:0] DIGIT_RESET = 2'd3;

  // avg * ref, and the rounding divide by 2 * 4095 through a reciprocal.
  localparam int PROD_W     = SAMPLE_W + REF_W;
  localparam int THR_PROD_W = THR_W + SAMPLE_W;
  localparam int NUM_W      = PROD_W + 2;
  localparam int FULL_SCALE = 4095;
  localparam int DIV_DEN    = 2 * FULL_SCALE;
  localparam int DIV_SH     = 40;
  localparam int DIV_MUL_W  = 28;
  localparam longint unsigned DIV_MUL = ((64'd1 << DIV_SH) + DIV_DEN - 1) / DIV_DEN;
  localparam int QUOT_W     = 14;

  // Decimal split of 0..999: /100 and /10 by reciprocal.
  localparam int DEC_W     = 16;
  localparam int TENS_MUL  = 41;
  localparam int TENS_SH   = 12;
  localparam int UNITS_MUL = 205;
  localparam int UNITS_SH  = 11;
  localparam int REM_W     = 7;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_e;

  typedef enum logic {
    CFG_REF_MV    = 1'b0,
    CFG_ALARM_THR = 1'b1
  } cfg_reg_e;

  typedef logic [DIGITS-1:0][SEG_W-1:0] codes_t;

  typedef struct packed {
    codes_t              codes;
    logic [TEMP_W-1:0]   tenths;
    logic                alarm;
  } reading_t;

  function automatic logic [SEG_W-1:0] seg_font(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/tssd_accum.sv
// Sample accumulator: running sum and count of the current averaging batch.
`timescale 1ns / 1ps

module tssd_accum #(
  parameter int SAMPLES_AVG = 16
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          add_i,
  input  logic [tssd_pkg::SAMPLE_W-1:0]                 sample_i,
  output logic                                          batch_o,
  output logic [$clog2(SAMPLES_AVG*4095+1)-1:0]         total_o
);
  import tssd_pkg::*;

  localparam int SUM_W = $clog2(SAMPLES_AVG * FULL_SCALE + 1);
  localparam int CNT_W = $clog2(SAMPLES_AVG + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_AVG - 1);

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign total_o = sum_q + SUM_W'(sample_i);
  assign batch_o = (cnt_q == CNT_LAST);

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (add_i) begin
      if (batch_o) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = total_o;
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> rtl/tssd_conv.sv
// Conversion pipe: batch average, scaling to tenths, alarm compare, digit codes.
`timescale 1ns / 1ps

module tssd_conv #(
  parameter int SAMPLES_AVG = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [$clog2(SAMPLES_AVG*4095+1)-1:0]  total_i,
  input  logic [tssd_pkg::REF_W-1:0]             ref_mv_i,
  input  logic [tssd_pkg::THR_W-1:0]             thr_i,
  input  logic                                   ack_i,
  output logic                                   done_o,
  output logic                                   busy_o,
  output tssd_pkg::reading_t                     reading_o
);
  import tssd_pkg::*;

  localparam int SUM_W  = $clog2(SAMPLES_AVG * FULL_SCALE + 1);
  localparam int AVG_SH = SUM_W + $clog2(SAMPLES_AVG) + 1;
  localparam int MUL_W  = AVG_SH + 1;
  localparam int AVGM_W = SUM_W + MUL_W;
  localparam longint unsigned AVG_MUL =
      ((64'd1 << AVG_SH) + SAMPLES_AVG - 1) / SAMPLES_AVG;
  localparam int DIVP_W = NUM_W + DIV_MUL_W;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  logic [SUM_W-1:0]      tot_q;
  logic [AVGM_W-1:0]     avgm_q;
  logic [PROD_W-1:0]     prod_q;
  logic [THR_PROD_W-1:0] thr_x_q;
  logic [QUOT_W-1:0]     quot_q;
  logic                  alarm_q;
  reading_t              reading_q, reading_d;

  logic [SAMPLE_W-1:0]   avg;
  logic [NUM_W-1:0]      num;
  logic [DIVP_W-1:0]     divp;

  assign avg  = avgm_q[AVG_SH +: SAMPLE_W];
  // 2*prod + 4095, then divide by 8190
  assign num  = {1'b0, prod_q, 1'b0} + NUM_W'(FULL_SCALE);
  assign divp = DIVP_W'(num) * DIVP_W'(DIV_MUL);

  always_ff @(posedge clk_i) begin
    if (start_i) tot_q <= total_i;
    if (v1_q) avgm_q <= AVGM_W'(tot_q) * AVGM_W'(AVG_MUL);
    if (v2_q) begin
      prod_q  <= PROD_W'(avg) * PROD_W'(ref_mv_i);
      thr_x_q <= {thr_i, {SAMPLE_W{1'b0}}} - THR_PROD_W'(thr_i);
    end
    if (v3_q) begin
      quot_q  <= divp[DIV_SH +: QUOT_W];
      alarm_q <= (prod_q >= PROD_W'(thr_x_q));
    end
  end

  // Clamp and decimal split.
  always_comb begin
    logic [TEMP_W-1:0]  t;
    logic [DEC_W-1:0]   tp;
    logic [DIGIT_W-1:0] tens, units, tenths;
    logic [REM_W-1:0]   r;
    logic [DEC_W-1:0]   up;
    t      = (quot_q > QUOT_W'(TEMP_MAX)) ? TEMP_MAX : quot_q[TEMP_W-1:0];
    tp     = DEC_W'(t) * DEC_W'(TENS_MUL);
    tens   = tp[TENS_SH +: DIGIT_W];
    r      = REM_W'(t - TEMP_W'(tens) * TEMP_W'(100));
    up     = DEC_W'(r) * DEC_W'(UNITS_MUL);
    units  = up[UNITS_SH +: DIGIT_W];
    tenths = DIGIT_W'(r - REM_W'(units) * REM_W'(10));
    reading_d.codes[0] = SEG_BLANK;
    reading_d.codes[1] = (tens != '0) ? seg_font(tens) : SEG_BLANK;
    reading_d.codes[2] = seg_font(units) | SEG_DP;
    reading_d.codes[3] = seg_font(tenths);
    reading_d.tenths   = t;
    reading_d.alarm    = alarm_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      reading_q <= '0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      // finished reading waits here until the result slot takes it
      v5_q <= v4_q | (v5_q & ~ack_i);
      if (v4_q) reading_q <= reading_d;
    end
  end

  assign done_o    = v5_q;
  assign busy_o    = v1_q | v2_q | v3_q | v4_q | v5_q;
  assign reading_o = reading_q;

endmodule

>>> rtl/tssd_scan.sv
// Digit scanner: steps to the next non-blank digit on each tick.
`timescale 1ns / 1ps

module tssd_scan (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       tick_i,
  input  tssd_pkg::codes_t           codes_i,
  output logic [tssd_pkg::SEG_W-1:0] seg_o,
  output logic [tssd_pkg::SEL_W-1:0] sel_n_o
);
  import tssd_pkg::*;

  logic [DIG_IDX_W-1:0] cur_q, cur_d;

  always_comb begin
    logic                 found;
    logic [DIG_IDX_W-1:0] d;
    found   = 1'b0;
    cur_d   = cur_q;
    seg_o   = SEG_BLANK;
    sel_n_o = SEL_NONE;
    // search starts one past the digit lit last
    for (int k = 1; k <= DIGITS; k++) begin
      d = cur_q + DIG_IDX_W'(k);
      if (!found && codes_i[d] != SEG_BLANK) begin
        found   = 1'b1;
        cur_d   = d;
        seg_o   = codes_i[d];
        sel_n_o = ~(SEL_W'(1) << d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= DIGIT_RESET;
    end else if (tick_i) begin
      cur_q <= cur_d;
    end
  end

endmodule

>>> rtl/thermometer_seven_segment_driver.sv
// Path: ticks and ordinary samples pass the input register, then the output
// register; the sample that closes a batch runs through the five-stage
// conversion pipe first. Throughput: one request per cycle while the output
// is not stalled; the input stalls while the conversion pipe runs.
// Reset: async active low; sums, display codes, reading and alarm cleared,
// scan pointer set to the last digit, registers to 5000 mV and 35.0 degrees.
`timescale 1ns / 1ps

module thermometer_seven_segment_driver #(
  parameter int SAMPLES_AVG = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // s_axis_tdata_i: [11:0] sample
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [tssd_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // s_axis_tuser_i: [0] command
  input  logic                            s_axis_tuser_i,
  // m_axis_tdata_o: [7:0] segments, [11:8] digit_select_n, [12] alarm,
  //                 [22:13] temp_tenths
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [tssd_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // m_axis_tuser_o: [0] reading_done
  output logic                            m_axis_tuser_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [tssd_pkg::REF_W-1:0]      cfg_data_i
);
  import tssd_pkg::*;

  localparam int SUM_W = $clog2(SAMPLES_AVG * FULL_SCALE + 1);

  logic [REF_W-1:0] ref_q;
  logic [THR_W-1:0] thr_q;

  logic                in_vld_q;
  cmd_e                in_cmd_q;
  logic [SAMPLE_W-1:0] in_smp_q;

  logic                out_vld_q;
  logic [SEG_W-1:0]    out_seg_q, out_seg_d;
  logic [SEL_W-1:0]    out_sel_q, out_sel_d;
  logic                out_alarm_q;
  logic [TEMP_W-1:0]   out_temp_q;
  logic                out_done_q;

  logic             out_free, consume, is_tick, is_sample, out_wr;
  logic             batch, conv_start, conv_done, conv_busy;
  logic [SUM_W-1:0] total;
  logic [SEG_W-1:0] scan_seg;
  logic [SEL_W-1:0] scan_sel;
  reading_t         reading;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= REF_RESET;
      thr_q <= THR_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_REF_MV:    ref_q <= cfg_data_i;
        CFG_ALARM_THR: thr_q <= cfg_data_i[THR_W-1:0];
        default:       ;
      endcase
    end
  end

  assign out_free  = !out_vld_q || m_axis_tready_i;
  // input item leaves the input register; held while a reading is in flight
  assign consume   = in_vld_q && out_free && !conv_busy;
  assign is_tick   = consume && (in_cmd_q == CMD_TICK);
  assign is_sample = consume && (in_cmd_q == CMD_SAMPLE);
  assign conv_start = is_sample && batch;
  assign out_wr    = (consume && !conv_start) || (conv_done && out_free);

  assign s_axis_tready_o = !in_vld_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_cmd_q <= cmd_e'(s_axis_tuser_i);
      in_smp_q <= s_axis_tdata_i[SAMPLE_W-1:0];
    end
  end

  tssd_accum #(
    .SAMPLES_AVG (SAMPLES_AVG)
  ) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .add_i    (is_sample),
    .sample_i (in_smp_q),
    .batch_o  (batch),
    .total_o  (total)
  );

  tssd_conv #(
    .SAMPLES_AVG (SAMPLES_AVG)
  ) u_conv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (conv_start),
    .total_i   (total),
    .ref_mv_i  (ref_q),
    .thr_i     (thr_q),
    .ack_i     (out_free),
    .done_o    (conv_done),
    .busy_o    (conv_busy),
    .reading_o (reading)
  );

  tssd_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (is_tick),
    .codes_i (reading.codes),
    .seg_o   (scan_seg),
    .sel_n_o (scan_sel)
  );

  // samples and finished readings drive the display dark
  assign out_seg_d = is_tick ? scan_seg : SEG_BLANK;
  assign out_sel_d = is_tick ? scan_sel : SEL_NONE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_wr) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_wr) begin
      out_seg_q   <= out_seg_d;
      out_sel_q   <= out_sel_d;
      out_alarm_q <= reading.alarm;
      out_temp_q  <= reading.tenths;
      out_done_q  <= conv_done;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_temp_q, out_alarm_q, out_sel_q, out_seg_q};
  assign m_axis_tuser_o  = out_done_q;

endmodule
